FILE: hdl/hexlvl_pkg.sv
package hexlvl_pkg;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_HEADER     = 2'd0,
      CSR_END_FIRST  = 2'd1,
      CSR_END_SECOND = 2'd2
   } csr_index_type;

   localparam logic [7:0] HEADER_RESET     = 8'd42;
   localparam logic [7:0] END_FIRST_RESET  = 8'd13;
   localparam logic [7:0] END_SECOND_RESET = 8'd10;

   // frame positions of the hex fields
   localparam int ID_POS    = 4;
   localparam int AD_POS    = 8;
   localparam int CHK_POS   = 12;
   localparam int SUM_BYTES = 12;

   localparam logic [29:0] HEIGHT_SCALE = 30'd10000;
   localparam logic [16:0] FULL_SCALE   = 17'd65535;

   // decoded frame, first pipeline stage
   typedef struct packed {
      logic [7:0]  sensor_id;
      logic [15:0] ad_value;
      logic [7:0]  chk;
      logic [7:0]  sum_lo;
      logic [7:0]  sum_hi;
   } dec_type;

   // scaled frame, second pipeline stage
   typedef struct packed {
      logic [7:0]  sensor_id;
      logic [15:0] ad_value;
      logic [29:0] product;
      logic        status;
   } scl_type;

   // ascii hex character to nibble, anything else reads as zero
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         n = c[3:0] + 4'd9;
      end
      return n;
   endfunction

endpackage

FILE: hdl/hexlvl_req_if.sv
interface hexlvl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/hexlvl_rsp_if.sv
interface hexlvl_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  sensor_id;
   logic [15:0] ad_value;
   logic [13:0] height_tenth_mm;
   logic        frame_status;

   modport source (output valid, output sensor_id, output ad_value,
                   output height_tenth_mm, output frame_status, input ready);
   modport sink (input valid, input sensor_id, input ad_value,
                 input height_tenth_mm, input frame_status, output ready);
endinterface

FILE: hdl/hexlvl_cell.sv
// one byte of the sliding window, shifts towards the head
module hexlvl_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift,
   input  logic [7:0] byte_from_next,
   output logic [7:0] byte_out,
   output logic [3:0] nibble_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = shift ? byte_from_next : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out   = byte_ff;
   assign nibble_out = hexlvl_pkg::hex_nibble(byte_ff);

endmodule

FILE: hdl/hex_ascii_level_frame_parser_core.sv
// a frame passes the decode, scale and output registers after the request with its last byte
// throughput: one request per cycle while not stalled; the window of cells shifts by one
// byte per request; a result waiting on the output does not stop requests until the scale
// and decode stages also fill; reset (synchronous, active high) clears the window, the byte
// count and the pipeline, and loads the header and end bytes with 42, 13 and 10
module hex_ascii_level_frame_parser_core #(
   parameter int FRAME_LEN = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   hexlvl_req_if.sink          req_chan,
   hexlvl_rsp_if.source        rsp_chan
);

   localparam int CntW = $clog2(FRAME_LEN + 1);

   // configuration registers
   logic [7:0] header_ff;
   logic [7:0] end_first_ff;
   logic [7:0] end_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff     <= hexlvl_pkg::HEADER_RESET;
         end_first_ff  <= hexlvl_pkg::END_FIRST_RESET;
         end_second_ff <= hexlvl_pkg::END_SECOND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            hexlvl_pkg::CSR_HEADER:     header_ff     <= csr_wdata;
            hexlvl_pkg::CSR_END_FIRST:  end_first_ff  <= csr_wdata;
            hexlvl_pkg::CSR_END_SECOND: end_second_ff <= csr_wdata;
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // pipeline handshake: each stage takes a new entry when empty or draining
   logic out_v_ff, s2_v_ff, s1_v_ff;
   logic rdy_out, rdy2, rdy1;
   logic accept;

   assign rdy_out = !out_v_ff || rsp_chan.ready;
   assign rdy2    = !s2_v_ff || rdy_out;
   assign rdy1    = !s1_v_ff || rdy2;
   assign req_chan.ready = rdy1;
   assign accept  = req_chan.valid && rdy1;

   // window of cells, index 0 is the oldest byte
   logic [7:0] win_byte [FRAME_LEN];
   logic [3:0] win_nib  [FRAME_LEN];

   for (genvar k = 0; k < FRAME_LEN; k++) begin : g_cell
      logic [7:0] feed;
      if (k == FRAME_LEN - 1) begin : g_tail
         assign feed = req_chan.rx_byte;
      end else begin : g_body
         assign feed = win_byte[k+1];
      end
      hexlvl_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .shift          (accept),
         .byte_from_next (feed),
         .byte_out       (win_byte[k]),
         .nibble_out     (win_nib[k])
      );
   end

   // bytes since the last frame, saturating at the frame length
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            long_enough;
   logic            match;

   // the frame is judged on the window as it will be after this shift,
   // so frame position p sits in cell p+1 right now
   assign long_enough = (cnt_ff >= CntW'(FRAME_LEN - 1));
   assign match = long_enough
               && (win_byte[1] == header_ff)
               && (win_byte[FRAME_LEN-1] == end_first_ff)
               && (req_chan.rx_byte == end_second_ff);

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (match) begin
            cnt_in = '0;
         end else if (cnt_ff < CntW'(FRAME_LEN)) begin
            cnt_in = cnt_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // stage 1: hex decode and checksum partial sums
   hexlvl_pkg::dec_type s1_ff, s1_in;
   logic s1_v_in;

   always_comb begin
      s1_in.sensor_id = {win_nib[hexlvl_pkg::ID_POS+1], win_nib[hexlvl_pkg::ID_POS+2]};
      s1_in.ad_value  = {win_nib[hexlvl_pkg::AD_POS+1], win_nib[hexlvl_pkg::AD_POS+2],
                         win_nib[hexlvl_pkg::AD_POS+3], win_nib[hexlvl_pkg::AD_POS+4]};
      s1_in.chk       = {win_nib[hexlvl_pkg::CHK_POS+1], win_nib[hexlvl_pkg::CHK_POS+2]};
      s1_in.sum_lo    = 8'd0;
      s1_in.sum_hi    = 8'd0;
      // two halves of six bytes each, combined in the next stage
      for (int i = 0; i < hexlvl_pkg::SUM_BYTES / 2; i++) begin
         s1_in.sum_lo = s1_in.sum_lo + win_byte[i+1];
         s1_in.sum_hi = s1_in.sum_hi + win_byte[i+1+hexlvl_pkg::SUM_BYTES/2];
      end
      s1_v_in = s1_v_ff && !rdy2;
      if (rdy1) begin
         s1_v_in = accept && match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && match) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: height product and checksum compare
   hexlvl_pkg::scl_type s2_ff, s2_in;
   logic [7:0] sum_full;

   always_comb begin
      sum_full        = s1_ff.sum_lo + s1_ff.sum_hi;
      s2_in.sensor_id = s1_ff.sensor_id;
      s2_in.ad_value  = s1_ff.ad_value;
      s2_in.product   = {14'd0, s1_ff.ad_value} * hexlvl_pkg::HEIGHT_SCALE;
      s2_in.status    = (sum_full != s1_ff.chk);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (rdy2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && s1_v_ff) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: divide by 65535 as p = q*65535 + (q + r) with q = p>>16,
   // q + r stays below twice 65535 so one compare corrects it
   logic [13:0] quot;
   logic [16:0] rem_sum;
   logic [13:0] height_in;

   always_comb begin
      quot      = s2_ff.product[29:16];
      rem_sum   = {3'd0, quot} + {1'b0, s2_ff.product[15:0]};
      height_in = quot;
      if (rem_sum >= hexlvl_pkg::FULL_SCALE) begin
         height_in = quot + 14'd1;
      end
   end

   logic [7:0]  id_ff;
   logic [15:0] ad_ff;
   logic [13:0] height_ff;
   logic        status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (rdy_out) begin
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out && s2_v_ff) begin
         id_ff     <= s2_ff.sensor_id;
         ad_ff     <= s2_ff.ad_value;
         height_ff <= height_in;
         status_ff <= s2_ff.status;
      end
   end

   assign rsp_chan.valid           = out_v_ff;
   assign rsp_chan.sensor_id       = id_ff;
   assign rsp_chan.ad_value        = ad_ff;
   assign rsp_chan.height_tenth_mm = height_ff;
   assign rsp_chan.frame_status    = status_ff;

   // checks
   a_cnt_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && match) |=> (cnt_ff == '0))
      else $error("byte count not cleared after a frame");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(FRAME_LEN))
      else $error("byte count past frame length");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (height_ff <= 14'd10000))
      else $error("height out of range");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !rdy2) |=> (s1_v_ff && $stable(s1_ff)))
      else $error("decoded frame lost while stalled");

endmodule

FILE: dv/hex_ascii_level_frame_parser_core_tb.sv
module hex_ascii_level_frame_parser_core_tb;

   localparam int FRAME_LEN   = 16;
   // how long a frame takes to leave the core after its last request, used to size waits
   localparam int LATENCY     = 3;
   // cycles without any request or reading moving before the run is abandoned
   localparam int STALL_LIMIT = 2000;
   // csr index with no register behind it, writes there must be ignored
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [7:0]  sensor_id;
      logic [15:0] ad_value;
      logic [13:0] height_tenth_mm;
      logic        frame_status;
   } level_reading_type;

   typedef logic [7:0] byte_seq_type [$];

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   hexlvl_req_if req_chan ();
   hexlvl_rsp_if rsp_chan ();

   hex_ascii_level_frame_parser_core #(
      .FRAME_LEN (FRAME_LEN)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #5 clock = ~clock;

   // our own copy of the register file and the byte window
   logic [7:0] cfg_header;
   logic [7:0] cfg_end_first;
   logic [7:0] cfg_end_second;
   logic [7:0] rx_window [FRAME_LEN];
   int         bytes_since_frame;

   // readings still owed by the core, oldest first
   level_reading_type level_readings [$];

   int   mismatch_count = 0;
   int   idle_cycles    = 0;
   // when set neither side idles
   logic calm           = 1'b0;

   // ---------------------------------------------------------------- hex helpers

   function automatic bit is_hex_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   // anything that is not a hex digit counts as zero
   function automatic logic [3:0] char_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h41 + 8'd10;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h61 + 8'd10;
      end
      return d[3:0];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) begin
         return 8'h30 + n;
      end
      return (lower ? 8'h61 : 8'h41) + n - 8'd10;
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (is_hex_char(c)) begin
         c = 8'($urandom_range(255));
      end
      return c;
   endfunction

   // ---------------------------------------------------------------- prediction

   // shift one accepted byte into the window and work out any reading it completes
   task automatic decode_rx_byte(input logic [7:0] b);
      level_reading_type r;
      logic [7:0]        sum;
      logic [7:0]        chk;
      logic [15:0]       ad;
      int unsigned       height;
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
         rx_window[i] = rx_window[i + 1];
      end
      rx_window[FRAME_LEN - 1] = b;
      if (bytes_since_frame < FRAME_LEN) begin
         bytes_since_frame++;
      end
      // a frame needs a full window since the last one, header first and end bytes last
      if (bytes_since_frame == FRAME_LEN && rx_window[0] == cfg_header &&
          rx_window[FRAME_LEN - 2] == cfg_end_first &&
          rx_window[FRAME_LEN - 1] == cfg_end_second) begin
         bytes_since_frame = 0;
         sum = 8'h00;
         for (int i = 0; i < 12; i++) begin
            sum = sum + rx_window[i];
         end
         chk = {char_value(rx_window[12]), char_value(rx_window[13])};
         ad  = {char_value(rx_window[8]), char_value(rx_window[9]),
                char_value(rx_window[10]), char_value(rx_window[11])};
         height = (32'(ad) * 32'd10000) / 32'd65535;
         r.sensor_id       = {char_value(rx_window[4]), char_value(rx_window[5])};
         r.ad_value        = ad;
         r.height_tenth_mm = height[13:0];
         r.frame_status    = (sum != chk);
         level_readings.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------- frame building

   // positions: 0 header, 4-5 id, 8-11 ad value, 12-13 checksum, last two end bytes,
   // the rest filler; junk_pct replaces hex characters with non-hex bytes,
   // plant_header puts the header byte at filler position 2
   function automatic byte_seq_type build_frame(input logic [7:0] id, input logic [15:0] ad,
                                                input bit lower, input bit bad_sum,
                                                input int junk_pct, input bit plant_header);
      byte_seq_type f;
      logic [7:0]   sum;
      logic [7:0]   chk;
      logic [7:0]   flip;
      f = {};
      f.push_back(cfg_header);
      for (int i = 1; i < 4; i++) begin
         f.push_back(8'($urandom_range(255)));
      end
      f.push_back(hex_char(id[7:4], lower));
      f.push_back(hex_char(id[3:0], lower));
      f.push_back(8'($urandom_range(255)));
      f.push_back(8'($urandom_range(255)));
      for (int i = 3; i >= 0; i--) begin
         f.push_back(hex_char(ad[i*4 +: 4], lower));
      end
      if (plant_header) begin
         f[2] = cfg_header;
      end
      foreach (f[i]) begin
         if ((i == 4 || i == 5 || i >= 8) && $urandom_range(99) < junk_pct) begin
            f[i] = junk_char();
         end
      end
      sum = 8'h00;
      foreach (f[i]) begin
         sum = sum + f[i];
      end
      flip = 8'($urandom_range(255, 1));
      chk  = bad_sum ? (sum ^ flip) : sum;
      f.push_back($urandom_range(99) < junk_pct ? junk_char() : hex_char(chk[7:4], lower));
      f.push_back(hex_char(chk[3:0], lower));
      f.push_back(cfg_end_first);
      f.push_back(cfg_end_second);
      return f;
   endfunction

   // ---------------------------------------------------------------- request side

   // one request; valid stays high afterwards so back-to-back bytes need no extra edge
   task automatic send_rx_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 38) begin
         req_chan.valid   <= 1'b0;
         req_chan.rx_byte <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      decode_rx_byte(b);
   endtask

   task automatic send_seq(input byte_seq_type s);
      foreach (s[i]) begin
         send_rx_byte(s[i]);
      end
   endtask

   // stop requesting until every owed reading is back and the pipeline is empty
   task automatic drain_readings();
      req_chan.valid <= 1'b0;
      while (level_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         hexlvl_pkg::CSR_HEADER:     cfg_header     = v;
         hexlvl_pkg::CSR_END_FIRST:  cfg_end_first  = v;
         hexlvl_pkg::CSR_END_SECOND: cfg_end_second = v;
         default: ;
      endcase
   endtask

   // new framing bytes, always with a stray write to the unused index as well
   task automatic program_levels(input logic [7:0] h, input logic [7:0] e1,
                                 input logic [7:0] e2);
      drain_readings();
      write_reg(hexlvl_pkg::CSR_HEADER, h);
      write_reg(CSR_SPARE, 8'($urandom_range(255)));
      write_reg(hexlvl_pkg::CSR_END_FIRST, e1);
      write_reg(hexlvl_pkg::CSR_END_SECOND, e2);
      csr_we <= 1'b0;
   endtask

   // mostly well-formed frames with random content, some broken ones and line noise
   task automatic random_traffic(input int n_bytes);
      int           sent;
      int           kind;
      int           cut;
      int           pos;
      bit           plant;
      logic [15:0]  ad;
      logic [7:0]   flip;
      byte_seq_type s;
      sent = 0;
      while (sent < n_bytes) begin
         kind = $urandom_range(99);
         case ($urandom_range(7))
            0:       ad = 16'h0000;
            1:       ad = 16'hFFFF;
            default: ad = 16'($urandom_range(16'hFFFF));
         endcase
         plant = ($urandom_range(99) < 10);
         s = build_frame(8'($urandom_range(255)), ad, 1'($urandom_range(1)),
                         $urandom_range(99) < 15, ($urandom_range(99) < 10) ? 30 : 0, plant);
         // end bytes right after a frame with a planted header: overlapping candidate
         if (plant) begin
            s.push_back(cfg_end_first);
            s.push_back(cfg_end_second);
         end
         if (kind >= 65 && kind < 80) begin
            if ($urandom_range(1) == 0) begin
               cut = $urandom_range(14, 1);
               repeat (cut) void'(s.pop_back());
            end else begin
               case ($urandom_range(2))
                  0:       pos = 0;
                  1:       pos = FRAME_LEN - 2;
                  default: pos = FRAME_LEN - 1;
               endcase
               flip   = 8'($urandom_range(255, 1));
               s[pos] = s[pos] ^ flip;
            end
         end else if (kind >= 80) begin
            s = {};
            repeat ($urandom_range(6, 1)) s.push_back(8'($urandom_range(255)));
         end
         send_seq(s);
         sent += s.size();
      end
   endtask

   // ---------------------------------------------------------------- tests

   // reset counts as a frame boundary, so a frame of the first sixteen bytes is taken,
   // and a second one straight after it as well
   task automatic test_first_frame_after_reset();
      send_seq(build_frame(8'h5A, 16'h1234, 1'b0, 1'b0, 0, 1'b0));
      send_seq(build_frame(8'hA5, 16'h8000, 1'b1, 1'b0, 0, 1'b0));
   endtask

   // smallest and largest id and ad value, both letter cases, non-hex fields, bad checksum
   task automatic test_field_extremes();
      send_seq(build_frame(8'h00, 16'h0000, 1'b0, 1'b0, 0, 1'b0));
      send_seq(build_frame(8'hFF, 16'hFFFF, 1'b0, 1'b0, 0, 1'b0));
      send_seq(build_frame(8'hFF, 16'hFFFF, 1'b1, 1'b0, 0, 1'b0));
      send_seq(build_frame(8'h3C, 16'h7FFF, 1'b0, 1'b1, 0, 1'b0));
      send_seq(build_frame(8'hC3, 16'hABCD, 1'b1, 1'b0, 100, 1'b0));
   endtask

   // a header inside the frame just taken must not start a new one
   task automatic test_overlap();
      byte_seq_type s;
      s = build_frame(8'h42, 16'h4242, 1'b0, 1'b0, 0, 1'b1);
      s.push_back(cfg_end_first);
      s.push_back(cfg_end_second);
      send_seq(s);
      send_seq(build_frame(8'h99, 16'h0001, 1'b0, 1'b0, 0, 1'b0));
   endtask

   task automatic test_register_extremes();
      program_levels(8'h00, 8'hFF, 8'h00);
      random_traffic(150);
      program_levels(8'hFF, 8'h00, 8'hFF);
      random_traffic(150);
   endtask

   task automatic test_random_traffic();
      program_levels(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
      random_traffic(200);
      // a long stretch where neither side idles
      calm = 1'b1;
      program_levels(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
      random_traffic(200);
      calm = 1'b0;
      program_levels(hexlvl_pkg::HEADER_RESET, hexlvl_pkg::END_FIRST_RESET,
                     hexlvl_pkg::END_SECOND_RESET);
      random_traffic(200);
      // hold off until the core has handed back everything
      drain_readings();
      random_traffic(200);
   endtask

   // ---------------------------------------------------------------- reading side

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // random backpressure on the reading channel and a check of every reading taken
   always @(posedge clock) begin : reading_check
      level_reading_type want;
      rsp_chan.ready <= calm || ($urandom_range(99) >= 38);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (level_readings.size() == 0) begin
            mismatch_count++;
            $display("%0t: reading expected none actual id %h ad %h height %0d status %b",
                     $time, rsp_chan.sensor_id, rsp_chan.ad_value,
                     rsp_chan.height_tenth_mm, rsp_chan.frame_status);
         end else begin
            want = level_readings.pop_front();
            check_field("sensor_id", 16'(want.sensor_id), 16'(rsp_chan.sensor_id));
            check_field("ad_value", want.ad_value, rsp_chan.ad_value);
            check_field("height_tenth_mm", 16'(want.height_tenth_mm),
                        16'(rsp_chan.height_tenth_mm));
            check_field("frame_status", 16'(want.frame_status), 16'(rsp_chan.frame_status));
         end
      end
   end

   // watchdog on cycles where nothing moves on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or reading moved for %0d cycles", $time, STALL_LIMIT);
         $display("** hex_ascii_level_frame_parser_core: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= hexlvl_pkg::CSR_HEADER;
      csr_wdata        <= 8'h00;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      cfg_header        = hexlvl_pkg::HEADER_RESET;
      cfg_end_first     = hexlvl_pkg::END_FIRST_RESET;
      cfg_end_second    = hexlvl_pkg::END_SECOND_RESET;
      bytes_since_frame = 0;
      foreach (rx_window[i]) begin
         rx_window[i] = 8'h00;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_first_frame_after_reset();
      test_field_extremes();
      test_overlap();
      test_register_extremes();
      test_random_traffic();

      // wait for the last readings and give stray ones time to show up
      drain_readings();
      repeat (4 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** hex_ascii_level_frame_parser_core: PASSED **");
      end else begin
         $display("** hex_ascii_level_frame_parser_core: FAILED **");
      end
      $finish;
   end

endmodule
